// ===== hdl/trat_pkg.sv =====
// ----------------------------------------------------------------------------
// Task runtime accounting table: shared definitions
// Operation codes, internal command codes, result status codes and the
// request token that travels along the row of slot cells.
// ----------------------------------------------------------------------------
package trat_pkg;

  localparam int SLOTS_DEF = 32;
  localparam int CPUS_DEF  = 1;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 224;

  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_STOP      = 3'd1,
    OP_SUSPEND   = 3'd2,
    OP_RESUME    = 3'd3,
    OP_MON_START = 3'd4,
    OP_MON_STOP  = 3'd5,
    OP_READ      = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_MISS    = 2'd1,
    STAT_IGNORED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    CMD_NONE     = 4'd0,
    CMD_START    = 4'd1,
    CMD_STOP     = 4'd2,
    CMD_SUSP_SYS = 4'd3,
    CMD_RES_SYS  = 4'd4,
    CMD_SUSP     = 4'd5,
    CMD_RES      = 4'd6,
    CMD_CLEAR    = 4'd7,
    CMD_READ     = 4'd8
  } cmd_t;

  // Request token. The cell that claims the request copies its slot contents
  // (after the update) into the capture fields and sets found.
  typedef struct packed {
    logic        active;
    cmd_t        cmd;
    logic        search;
    status_t     fixed_status;
    logic [15:0] id;
    logic [63:0] now;
    logic [4:0]  ridx;
    logic        found;
    logic [4:0]  slot;
    logic        in_use;
    logic [15:0] owner;
    logic [63:0] total;
    logic [63:0] stamp;
  } tok_t;

  typedef struct packed {
    logic [63:0] window_start;
    logic [5:0]  active_tasks;
    logic [63:0] run_start;
    logic [63:0] runtime;
    logic [15:0] slot_task;
    logic        slot_in_use;
    logic [4:0]  slot;
    status_t     status;
  } res_t;

endpackage

// ===== hdl/task_runtime_accounting_table.sv =====
// ----------------------------------------------------------------------------
// Task runtime accounting table
// Per-task runtime table kept up to date by scheduler events, built as a row
// of slot cells through which each event travels as a token.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the s_axis channel, one transfer per event, and each
//   event gives exactly one result transfer on the m_axis channel.
//   The cfg channel writes the enable bit; it is always ready and should be
//   written only while no event is in flight.
//   An event passes through the SLOTS cells in order, each cell acting on its
//   own slot and registering the token before it hands it on; the result is
//   registered in the output register, and a new event is taken only after
//   the last one has left the cell row.
//   A result waiting on a stalled receiver does not block the next event:
//   one further result is parked in a holding register, and s_axis_tready
//   falls only while that register is occupied or an event is in the row.
//   Reset is synchronous; it loads the system slots (owners 0 to CPUS-1),
//   clears all other slots, the monitor count and the window start, and
//   sets enable. The table is usable in the cycle after reset.
// ----------------------------------------------------------------------------
module task_runtime_accounting_table #(
  parameter int SLOTS = trat_pkg::SLOTS_DEF,
  parameter int CPUS  = trat_pkg::CPUS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // cfg_data: enable
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_data,
  // s_axis_tdata: operation[2:0], task_id[18:3], now_time[82:19], slot_index[87:83]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [trat_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // m_axis_tdata: status[1:0], slot[6:2], slot_in_use[7], slot_task[23:8],
  // runtime[87:24], run_start[151:88], active_tasks[157:152],
  // window_start[221:158], zero padding[223:222]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [trat_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int SYS_SLOTS = (CPUS < SLOTS) ? CPUS : SLOTS;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t         state;
  state_t         state_next;
  logic           enable;
  logic [7:0]     monitor_users;
  logic [7:0]     monitor_users_next;
  logic [63:0]    window_start;
  logic [63:0]    window_start_next;
  logic [CNT_W-1:0] task_total;
  logic [CNT_W-1:0] task_total_next;
  logic [8:0]     task_total_wide;

  trat_pkg::res_t out_res;
  trat_pkg::res_t hold_res;
  trat_pkg::res_t exit_res;
  logic           out_valid;
  logic           hold_valid;

  trat_pkg::tok_t link [SLOTS+1];
  trat_pkg::tok_t issue;
  trat_pkg::tok_t exit_tok;
  logic [SLOTS:0] live;

  logic           in_accept;
  logic [2:0]     in_op;
  logic [15:0]    in_id;
  logic [63:0]    in_now;
  logic [4:0]     in_ridx;
  logic           in_sched;
  logic           in_sys;
  logic           exit_valid;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE) && !hold_valid;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign in_op   = s_axis_tdata[2:0];
  assign in_id   = s_axis_tdata[18:3];
  assign in_now  = s_axis_tdata[82:19];
  assign in_ridx = s_axis_tdata[87:83];

  assign in_sched = (in_op == trat_pkg::OP_START) || (in_op == trat_pkg::OP_STOP) ||
                    (in_op == trat_pkg::OP_SUSPEND) || (in_op == trat_pkg::OP_RESUME);
  assign in_sys   = (32'(in_id) < 32'(CPUS));

  // Decode an accepted event into the row token and the next monitor count and window start.
  always_comb begin
    issue              = '0;
    issue.active       = in_accept;
    issue.cmd          = trat_pkg::CMD_NONE;
    issue.fixed_status = trat_pkg::STAT_IGNORED;
    issue.id           = in_id;
    issue.now          = in_now;
    issue.ridx         = in_ridx;
    monitor_users_next = monitor_users;
    window_start_next  = window_start;
    if (in_accept) begin
      priority if (in_sched && !enable) begin
        issue.cmd = trat_pkg::CMD_NONE;
      end else begin
        unique case (in_op)
          trat_pkg::OP_START: begin
            issue.cmd    = trat_pkg::CMD_START;
            issue.search = 1'b1;
          end
          trat_pkg::OP_STOP: begin
            issue.cmd    = trat_pkg::CMD_STOP;
            issue.search = 1'b1;
          end
          trat_pkg::OP_SUSPEND: begin
            if (in_sys) begin
              issue.cmd    = trat_pkg::CMD_SUSP_SYS;
              issue.search = 1'b1;
            end else if (monitor_users != 8'd0) begin
              issue.cmd    = trat_pkg::CMD_SUSP;
              issue.search = 1'b1;
            end
          end
          trat_pkg::OP_RESUME: begin
            if (in_sys) begin
              issue.cmd    = trat_pkg::CMD_RES_SYS;
              issue.search = 1'b1;
            end else if (monitor_users != 8'd0) begin
              issue.cmd    = trat_pkg::CMD_RES;
              issue.search = 1'b1;
            end
          end
          trat_pkg::OP_MON_START: begin
            issue.fixed_status = trat_pkg::STAT_DONE;
            if (monitor_users == 8'd0) begin
              issue.cmd         = trat_pkg::CMD_CLEAR;
              window_start_next = in_now;
            end
            if (monitor_users != 8'hFF) begin
              monitor_users_next = monitor_users + 8'd1;
            end
          end
          trat_pkg::OP_MON_STOP: begin
            issue.fixed_status = trat_pkg::STAT_DONE;
            monitor_users_next = (monitor_users <= 8'd1) ? 8'd0 : monitor_users - 8'd1;
          end
          trat_pkg::OP_READ: begin
            issue.cmd    = trat_pkg::CMD_READ;
            issue.search = 1'b1;
          end
          default: begin
            issue.cmd = trat_pkg::CMD_NONE;
          end
        endcase
      end
    end
  end

  assign link[0] = issue;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    trat_cell #(
      .INDEX (g),
      .CPUS  (CPUS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (link[g]),
      .tok_out (link[g+1])
    );
  end

  for (genvar g = 0; g <= SLOTS; g++) begin : g_live
    assign live[g] = link[g].active;
  end

  assign exit_tok   = link[SLOTS];
  assign exit_valid = exit_tok.active;

  always_comb begin
    task_total_next = task_total;
    if (exit_valid && exit_tok.found) begin
      if (exit_tok.cmd == trat_pkg::CMD_START) begin
        task_total_next = task_total + CNT_W'(1);
      end else if ((exit_tok.cmd == trat_pkg::CMD_STOP) && (task_total != '0)) begin
        task_total_next = task_total - CNT_W'(1);
      end
    end
  end

  assign task_total_wide = 9'(task_total_next);

  always_comb begin
    exit_res              = '0;
    exit_res.status       = exit_tok.search ?
                            (exit_tok.found ? trat_pkg::STAT_DONE : trat_pkg::STAT_MISS) :
                            exit_tok.fixed_status;
    exit_res.slot         = exit_tok.slot;
    exit_res.slot_in_use  = exit_tok.in_use;
    exit_res.slot_task    = exit_tok.owner;
    exit_res.runtime      = exit_tok.total;
    exit_res.run_start    = exit_tok.stamp;
    exit_res.active_tasks = task_total_wide[5:0];
    exit_res.window_start = window_start;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_accept) begin
        state_next = ST_SCAN;
      end
      ST_SCAN: if (exit_valid) begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      enable        <= 1'b1;
      monitor_users <= '0;
      window_start  <= '0;
      task_total    <= CNT_W'(SYS_SLOTS);
    end else begin
      state         <= state_next;
      monitor_users <= monitor_users_next;
      window_start  <= window_start_next;
      task_total    <= task_total_next;
      if (cfg_valid && cfg_ready) begin
        enable <= cfg_data;
      end
    end
  end

  // Output register with one holding stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (exit_valid) begin
        if (!out_valid || m_axis_tready) begin
          out_valid <= 1'b1;
        end else begin
          hold_valid <= 1'b1;
        end
      end else if (out_valid && m_axis_tready) begin
        if (hold_valid) begin
          hold_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exit_valid) begin
      if (!out_valid || m_axis_tready) begin
        out_res <= exit_res;
      end else begin
        hold_res <= exit_res;
      end
    end else if (out_valid && m_axis_tready && hold_valid) begin
      out_res <= hold_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_res};

  a_hold_behind_out: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> out_valid)
    else $error("holding register occupied while output register is empty");

  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $countones(live) <= 1)
    else $error("more than one event travelling along the cell row");

  a_exit_in_scan: assert property (@(posedge clk) disable iff (rst)
    exit_valid |-> (state == ST_SCAN))
    else $error("token left the cell row while no event was in flight");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_SCAN) && !s_axis_tready)
    else $error("input transfer did not start a scan");

  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(task_total) <= 32'(SLOTS))
    else $error("active task count exceeds the number of slots");

endmodule

// ===== hdl/trat_cell.sv =====
// ----------------------------------------------------------------------------
// Task runtime accounting table: slot cell
// Holds one slot of the table, acts on the request token as it passes and
// hands the registered token on to the next cell in the cycle after.
// ----------------------------------------------------------------------------
module trat_cell #(
  parameter int INDEX = 0,
  parameter int CPUS  = trat_pkg::CPUS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  trat_pkg::tok_t  tok_in,
  output trat_pkg::tok_t  tok_out
);

  localparam logic [15:0] CELL_ID  = 16'(INDEX);
  localparam logic        IS_SYS   = (INDEX < CPUS);

  logic        valid;
  logic [15:0] owner;
  logic [63:0] total;
  logic [63:0] stamp;

  logic        valid_next;
  logic [15:0] owner_next;
  logic [63:0] total_next;
  logic [63:0] stamp_next;
  logic        hit;
  logic        owns;
  logic [63:0] elapsed;
  trat_pkg::tok_t tok_next;

  assign owns    = !tok_in.found && valid && (owner == tok_in.id);
  assign elapsed = tok_in.now - stamp;

  always_comb begin
    valid_next = valid;
    owner_next = owner;
    total_next = total;
    stamp_next = stamp;
    hit        = 1'b0;
    tok_next   = tok_in;
    if (tok_in.active) begin
      unique case (tok_in.cmd)
        trat_pkg::CMD_START: begin
          hit = !tok_in.found && !valid;
          if (hit) begin
            valid_next = 1'b1;
            owner_next = tok_in.id;
            total_next = '0;
            stamp_next = '0;
          end
        end
        trat_pkg::CMD_STOP: begin
          hit = owns;
          if (hit) begin
            valid_next = 1'b0;
            owner_next = '0;
            total_next = '0;
            stamp_next = '0;
          end
        end
        trat_pkg::CMD_SUSP_SYS: begin
          hit = (tok_in.id == CELL_ID);
          if (hit) begin
            total_next = total + elapsed;
          end
        end
        trat_pkg::CMD_RES_SYS: begin
          hit = (tok_in.id == CELL_ID);
          if (hit) begin
            stamp_next = tok_in.now;
          end
        end
        trat_pkg::CMD_SUSP: begin
          hit = owns;
          // A run that was never stamped adds nothing.
          if (hit && (stamp != '0)) begin
            total_next = total + elapsed;
          end
        end
        trat_pkg::CMD_RES: begin
          hit = owns;
          if (hit) begin
            stamp_next = tok_in.now;
          end
        end
        trat_pkg::CMD_CLEAR: begin
          if (!IS_SYS) begin
            total_next = '0;
            stamp_next = '0;
          end
        end
        trat_pkg::CMD_READ: begin
          hit = (16'(tok_in.ridx) == CELL_ID);
        end
        trat_pkg::CMD_NONE: begin
          hit = 1'b0;
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end
    if (hit) begin
      tok_next.found  = 1'b1;
      tok_next.slot   = CELL_ID[4:0];
      tok_next.in_use = valid_next;
      tok_next.owner  = owner_next;
      tok_next.total  = total_next;
      tok_next.stamp  = stamp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= IS_SYS;
      owner   <= IS_SYS ? CELL_ID : 16'd0;
      total   <= '0;
      stamp   <= '0;
      tok_out <= '0;
    end else begin
      valid   <= valid_next;
      owner   <= owner_next;
      total   <= total_next;
      stamp   <= stamp_next;
      tok_out <= tok_next;
    end
  end

endmodule
